// ===== src/tsrrs_pkg.sv =====
`default_nettype none
package tsrrs_pkg;

   localparam int WORKER_COUNT_DEF = 16;

   typedef logic [2:0] mode_type;
   typedef logic [2:0] status_type;
   typedef logic [2:0] life_type;
   typedef logic [4:0] slot_port_type;

   // Event codes
   localparam mode_type MODE_INIT   = 3'd0;
   localparam mode_type MODE_CREATE = 3'd1;
   localparam mode_type MODE_START  = 3'd2;
   localparam mode_type MODE_YIELD  = 3'd3;
   localparam mode_type MODE_TICK   = 3'd4;
   localparam mode_type MODE_JOIN   = 3'd5;
   localparam mode_type MODE_EXIT   = 3'd6;

   // Result status codes
   localparam status_type STAT_OK       = 3'd0;
   localparam status_type STAT_ERROR    = 3'd1;
   localparam status_type STAT_BLOCKED  = 3'd2;
   localparam status_type STAT_PROC_END = 3'd3;
   localparam status_type STAT_FATAL    = 3'd4;

   // Slot life states
   localparam life_type LIFE_FREE     = 3'd0;
   localparam life_type LIFE_RUNNING  = 3'd1;
   localparam life_type LIFE_RUNNABLE = 3'd2;
   localparam life_type LIFE_BLOCKED  = 3'd3;
   localparam life_type LIFE_ZOMBIE   = 3'd4;

endpackage
`default_nettype wire

// ===== src/thread_slot_round_robin_scheduler_top.sv =====
// Round-robin thread slot scheduler.
//
// Input channel (req_*): one word per scheduling event, req_mode selects init, create,
// start, yield, tick, join or exit; req_target_slot names the slot for a join. A word is
// taken when req_valid is high and req_stall is low. The block works on one event at a
// time and holds req_stall high from acceptance until the result is in the output register.
//
// Result channel (rsp_*): exactly one word per event: status, slot allocated by create,
// slot running afterwards, and whether the running slot changed. The word sits in an
// output register; while rsp_stall is high it holds, and the block already takes the next
// event and works on it, finishing only once that register is free.
//
// Init, start and events refused at decode go from S_DECODE straight to S_DONE; a join
// settled on the target's state goes through S_JN_CHECK. Scans read one slot per cycle
// through the life memory's single read port; create, yield, tick, exit and a blocking
// join scan, then pass S_POST and, where the running slot changes, the write states. The
// next word is taken only after the result has been loaded into the output register.
//
// Reset: clears control state and the per-entry valid bits, so every slot reads as free
// with no joiner at once; no clearing pass follows and the block is ready right away.
`default_nettype none
module thread_slot_round_robin_scheduler_top #(
   parameter int WORKER_COUNT = tsrrs_pkg::WORKER_COUNT_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  tsrrs_pkg::mode_type        req_mode,
   input  tsrrs_pkg::slot_port_type   req_target_slot,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output tsrrs_pkg::status_type      rsp_status,
   output tsrrs_pkg::slot_port_type   rsp_new_slot,
   output tsrrs_pkg::slot_port_type   rsp_running_slot,
   output logic                       rsp_switched
);
   import tsrrs_pkg::*;

   localparam int SLOT_TOTAL = WORKER_COUNT + 1;
   localparam int SW         = $clog2(SLOT_TOTAL);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_TOTAL - 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_JN_CHECK = 4'd2;
   localparam logic [3:0] S_EX_JCHK  = 4'd3;
   localparam logic [3:0] S_EX_LCHK  = 4'd4;
   localparam logic [3:0] S_SEARCH   = 4'd5;
   localparam logic [3:0] S_POST     = 4'd6;
   localparam logic [3:0] S_WR_OLD   = 4'd7;
   localparam logic [3:0] S_WR_NEW   = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   // Control state
   logic [3:0]            state_ff, state_in;
   logic [SW-1:0]         cur_ff, cur_in;
   logic                  init_ff, init_in;
   logic                  started_ff, started_in;
   logic [SLOT_TOTAL-1:0] life_vld_ff, life_vld_in;
   logic [SLOT_TOTAL-1:0] join_vld_ff, join_vld_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic                  rsp_valid_ff;

   // Event and working registers
   mode_type              mode_ff, mode_in;
   slot_port_type         tgt_ff, tgt_in;
   logic [SW-1:0]         before_ff, before_in;
   status_type            status_ff, status_in;
   logic [SW-1:0]         new_slot_ff, new_slot_in;
   logic [SW-1:0]         srch_addr_ff, srch_addr_in;
   logic [SW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]         chk_addr_ff, chk_addr_in;
   life_type              want_ff, want_in;
   logic                  found_ff, found_in;
   logic [SW-1:0]         nxt_ff, nxt_in;
   logic [SW-1:0]         jslot_ff, jslot_in;

   // Output register
   status_type            rsp_status_ff;
   slot_port_type         rsp_new_slot_ff;
   slot_port_type         rsp_running_slot_ff;
   logic                  rsp_switched_ff;

   // Memories: slot life, and joiner record {present, slot}
   life_type              life_mem [SLOT_TOTAL];
   logic [SW:0]           join_mem [SLOT_TOTAL];
   life_type              life_rd_ff;
   logic                  life_rv_ff;
   logic [SW:0]           join_rd_ff;
   logic                  join_rv_ff;

   logic [SW-1:0]         life_ra, life_wa, join_ra, join_wa;
   logic                  life_we, join_we, tbl_clear;
   life_type              life_wd;
   logic [SW:0]           join_wd;

   life_type              life_q;
   logic                  join_q_pres;
   logic [SW-1:0]         join_q_slot;

   logic [SW+4:0]         tgt_wide, cur_wide, new_wide;
   logic [SW-1:0]         tgt_slot, cur_succ, srch_succ;
   logic                  tgt_range_bad, tgt_is_cur, tgt_zero;
   logic                  accept, load, hit, issue;

   // Entries never written since reset or init read as free with no joiner.
   assign life_q      = life_rv_ff ? life_rd_ff : LIFE_FREE;
   assign join_q_pres = join_rv_ff & join_rd_ff[SW];
   assign join_q_slot = join_rv_ff ? join_rd_ff[SW-1:0] : '0;

   assign tgt_wide      = {{SW{1'b0}}, tgt_ff};
   assign tgt_slot      = tgt_wide[SW-1:0];
   assign cur_wide      = {5'b0, cur_ff};
   assign new_wide      = {5'b0, new_slot_ff};
   assign tgt_range_bad = ({2'b0, tgt_ff} >= 7'(SLOT_TOTAL));
   assign tgt_is_cur    = (tgt_wide == cur_wide);
   assign tgt_zero      = (tgt_ff == '0);

   // Circular successors
   assign cur_succ  = (cur_ff == LAST_SLOT) ? '0 : cur_ff + 1'b1;
   assign srch_succ = (srch_addr_ff == LAST_SLOT) ? '0 : srch_addr_ff + 1'b1;

   assign accept = req_valid && !req_stall;
   assign load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign issue  = (cnt_ff != '0);
   assign hit    = chk_vld_ff && (life_q == want_ff);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      init_in      = init_ff;
      started_in   = started_ff;
      mode_in      = mode_ff;
      tgt_in       = tgt_ff;
      before_in    = before_ff;
      status_in    = status_ff;
      new_slot_in  = new_slot_ff;
      srch_addr_in = srch_addr_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = 1'b0;
      chk_addr_in  = chk_addr_ff;
      want_in      = want_ff;
      found_in     = found_ff;
      nxt_in       = nxt_ff;
      jslot_in     = jslot_ff;

      life_ra   = srch_addr_ff;
      join_ra   = cur_ff;
      life_we   = 1'b0;
      life_wa   = cur_ff;
      life_wd   = LIFE_FREE;
      join_we   = 1'b0;
      join_wa   = tgt_slot;
      join_wd   = '0;
      tbl_clear = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               tgt_in    = req_target_slot;
               before_in = cur_ff;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in   = STAT_OK;
            new_slot_in = '0;
            state_in    = S_DONE;
            unique case (mode_ff) inside
               MODE_INIT: begin
                  if (init_ff) begin
                     status_in = STAT_ERROR;
                  end else begin
                     // Wipe the table, then make the main thread running.
                     tbl_clear = 1'b1;
                     life_we   = 1'b1;
                     life_wa   = '0;
                     life_wd   = LIFE_RUNNING;
                     cur_in    = '0;
                     init_in   = 1'b1;
                  end
               end
               MODE_CREATE: begin
                  if (!init_ff) begin
                     status_in = STAT_ERROR;
                  end else begin
                     srch_addr_in = SW'(1);
                     cnt_in       = LAST_SLOT;
                     want_in      = LIFE_FREE;
                     state_in     = S_SEARCH;
                  end
               end
               MODE_START: begin
                  if (!init_ff) begin
                     status_in = STAT_ERROR;
                  end else begin
                     started_in = 1'b1;
                  end
               end
               MODE_YIELD, MODE_TICK: begin
                  if (started_ff) begin
                     srch_addr_in = cur_succ;
                     cnt_in       = LAST_SLOT;
                     want_in      = LIFE_RUNNABLE;
                     state_in     = S_SEARCH;
                  end
               end
               MODE_JOIN: begin
                  if (!init_ff || tgt_zero || tgt_range_bad || tgt_is_cur) begin
                     status_in = STAT_ERROR;
                  end else begin
                     life_ra  = tgt_slot;
                     join_ra  = tgt_slot;
                     state_in = S_JN_CHECK;
                  end
               end
               MODE_EXIT: begin
                  if (!init_ff || (cur_ff == '0)) begin
                     status_in = STAT_PROC_END;
                  end else begin
                     life_we  = 1'b1;
                     life_wa  = cur_ff;
                     life_wd  = LIFE_ZOMBIE;
                     join_ra  = cur_ff;
                     state_in = S_EX_JCHK;
                  end
               end
               default: begin
                  status_in = STAT_ERROR;
               end
            endcase
         end

         S_JN_CHECK: begin
            if (life_q == LIFE_FREE) begin
               status_in = STAT_ERROR;
               state_in  = S_DONE;
            end else if (life_q == LIFE_ZOMBIE) begin
               life_we  = 1'b1;
               life_wa  = tgt_slot;
               life_wd  = LIFE_FREE;
               join_we  = 1'b1;
               join_wa  = tgt_slot;
               join_wd  = '0;
               state_in = S_DONE;
            end else if (join_q_pres && (join_q_slot != cur_ff)) begin
               status_in = STAT_ERROR;
               state_in  = S_DONE;
            end else begin
               srch_addr_in = cur_succ;
               cnt_in       = LAST_SLOT;
               want_in      = LIFE_RUNNABLE;
               state_in     = S_SEARCH;
            end
         end

         S_EX_JCHK: begin
            if (join_q_pres) begin
               life_ra  = join_q_slot;
               jslot_in = join_q_slot;
               state_in = S_EX_LCHK;
            end else begin
               srch_addr_in = cur_succ;
               cnt_in       = LAST_SLOT;
               want_in      = LIFE_RUNNABLE;
               state_in     = S_SEARCH;
            end
         end

         S_EX_LCHK: begin
            // Wake the joiner before the scan so that it can be picked.
            if (life_q == LIFE_BLOCKED) begin
               life_we = 1'b1;
               life_wa = jslot_ff;
               life_wd = LIFE_RUNNABLE;
            end
            srch_addr_in = cur_succ;
            cnt_in       = LAST_SLOT;
            want_in      = LIFE_RUNNABLE;
            state_in     = S_SEARCH;
         end

         S_SEARCH: begin
            // Issue one read per cycle and check the word read the cycle before.
            life_ra = srch_addr_ff;
            if (issue) begin
               srch_addr_in = srch_succ;
               cnt_in       = cnt_ff - 1'b1;
               chk_vld_in   = 1'b1;
               chk_addr_in  = srch_addr_ff;
            end
            if (hit) begin
               found_in   = 1'b1;
               nxt_in     = chk_addr_ff;
               chk_vld_in = 1'b0;
               state_in   = S_POST;
            end else if (chk_vld_ff && !issue) begin
               found_in = 1'b0;
               state_in = S_POST;
            end
         end

         S_POST: begin
            state_in = S_DONE;
            unique case (mode_ff) inside
               MODE_CREATE: begin
                  if (found_ff) begin
                     life_we     = 1'b1;
                     life_wa     = nxt_ff;
                     life_wd     = LIFE_RUNNABLE;
                     join_we     = 1'b1;
                     join_wa     = nxt_ff;
                     join_wd     = '0;
                     new_slot_in = nxt_ff;
                  end else begin
                     status_in = STAT_ERROR;
                  end
               end
               MODE_YIELD, MODE_TICK: begin
                  if (found_ff) begin
                     state_in = S_WR_OLD;
                  end
               end
               MODE_JOIN: begin
                  if (found_ff) begin
                     status_in = STAT_BLOCKED;
                     state_in  = S_WR_OLD;
                  end else begin
                     status_in = STAT_ERROR;
                  end
               end
               MODE_EXIT: begin
                  if (found_ff) begin
                     state_in = S_WR_NEW;
                  end else begin
                     status_in = STAT_FATAL;
                  end
               end
               default: begin
                  status_in = STAT_ERROR;
               end
            endcase
         end

         S_WR_OLD: begin
            life_we = 1'b1;
            life_wa = cur_ff;
            if (mode_ff == MODE_JOIN) begin
               life_wd = LIFE_BLOCKED;
               join_we = 1'b1;
               join_wa = tgt_slot;
               join_wd = {1'b1, cur_ff};
            end else begin
               life_wd = LIFE_RUNNABLE;
            end
            state_in = S_WR_NEW;
         end

         S_WR_NEW: begin
            life_we  = 1'b1;
            life_wa  = nxt_ff;
            life_wd  = LIFE_RUNNING;
            cur_in   = nxt_ff;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Valid bits: clear all on init, set on every write.
   always_comb begin
      life_vld_in = life_vld_ff;
      join_vld_in = join_vld_ff;
      if (tbl_clear) begin
         life_vld_in = '0;
         join_vld_in = '0;
      end
      if (life_we) begin
         life_vld_in[life_wa] = 1'b1;
      end
      if (join_we) begin
         join_vld_in[join_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (life_we) begin
         life_mem[life_wa] <= life_wd;
      end
      life_rd_ff <= life_mem[life_ra];
      life_rv_ff <= life_vld_ff[life_ra];
   end

   always_ff @(posedge clock) begin
      if (join_we) begin
         join_mem[join_wa] <= join_wd;
      end
      join_rd_ff <= join_mem[join_ra];
      join_rv_ff <= join_vld_ff[join_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cur_ff      <= '0;
         init_ff     <= 1'b0;
         started_ff  <= 1'b0;
         life_vld_ff <= '0;
         join_vld_ff <= '0;
         chk_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_ff      <= cur_in;
         init_ff     <= init_in;
         started_ff  <= started_in;
         life_vld_ff <= life_vld_in;
         join_vld_ff <= join_vld_in;
         chk_vld_ff  <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      tgt_ff       <= tgt_in;
      before_ff    <= before_in;
      status_ff    <= status_in;
      new_slot_ff  <= new_slot_in;
      srch_addr_ff <= srch_addr_in;
      cnt_ff       <= cnt_in;
      chk_addr_ff  <= chk_addr_in;
      want_ff      <= want_in;
      found_ff     <= found_in;
      nxt_ff       <= nxt_in;
      jslot_ff     <= jslot_in;
   end

   // Output register: load when free or draining, drop valid once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff       <= status_ff;
         rsp_new_slot_ff     <= new_wide[4:0];
         rsp_running_slot_ff <= cur_wide[4:0];
         rsp_switched_ff     <= (cur_ff != before_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_new_slot     = rsp_new_slot_ff;
   assign rsp_running_slot = rsp_running_slot_ff;
   assign rsp_switched     = rsp_switched_ff;

endmodule
`default_nettype wire

// ===== src/tsrrs_checker.sv =====
`default_nettype none
module tsrrs_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_stall,
   input wire                        rsp_valid,
   input wire                        rsp_stall,
   input tsrrs_pkg::status_type      rsp_status,
   input tsrrs_pkg::slot_port_type   rsp_new_slot,
   input tsrrs_pkg::slot_port_type   rsp_running_slot,
   input wire                        rsp_switched
);
   import tsrrs_pkg::*;

   logic          rsp_take;
   slot_port_type last_slot_ff, last_slot_in;

   assign rsp_take     = rsp_valid && !rsp_stall;
   assign last_slot_in = rsp_take ? rsp_running_slot : last_slot_ff;

   // Track the running slot reported by the last word.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_slot_ff <= '0;
      end else begin
         last_slot_ff <= last_slot_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_new_slot)
         && $stable(rsp_running_slot) && $stable(rsp_switched))
      else $error("result word changed while stalled");

   a_switch_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_switched == (rsp_running_slot != last_slot_ff)))
      else $error("switched flag disagrees with running slot history");

   a_fail_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_take && (rsp_status == STAT_ERROR || rsp_status == STAT_PROC_END
         || rsp_status == STAT_FATAL) |-> !rsp_switched && (rsp_new_slot == '0))
      else $error("failed event switched or allocated a slot");

   a_block_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_take && (rsp_status == STAT_BLOCKED) |-> rsp_switched)
      else $error("blocked caller without a switch");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while an event is in progress");

endmodule

bind thread_slot_round_robin_scheduler_top tsrrs_checker u_tsrrs_checker (.*);
`default_nettype wire
